[hw/rtl/fac_pkg.sv]
package fac_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int ELEM_W      = 32;
   localparam int COEF_W      = ELEM_W + 1;
   localparam int PROD_W      = COEF_W + ELEM_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int NUM_PLANES  = 6;
   localparam int CELL_STAGES = 3;
   localparam int REQ_TDATA_W = 232;
   localparam int RSP_TDATA_W = 8;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_BOX   = 1'b1
   } opcode_type;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   typedef struct packed {
      logic       valid;
      opcode_type opcode;
      logic [1:0] elem_col;
      logic [1:0] elem_row;
      elem_type   elem_value;
      elem_type   box_min_x;
      elem_type   box_min_y;
      elem_type   box_min_z;
      elem_type   box_max_x;
      elem_type   box_max_y;
      elem_type   box_max_z;
      logic       visible;
   } item_type;

endpackage

[hw/rtl/frustum_aabb_cull.sv]
// frustum_aabb_cull: tests axis-aligned boxes against the six planes of a
// 4x4 view-projection matrix held in the block.
// req channel: tuser[0] is the opcode (0 writes one matrix element, 1 tests a
// box); tdata carries the element address and value and the box corners.
// rsp channel: one transaction per box, tdata[0] = visible. writes give none.
// the box travels through a row of six plane cells, three register stages
// each; a write travels the same row and updates each cell as it passes, so
// every box sees exactly the writes accepted before it.
// throughput: one transaction per cycle while req_tready is high, set by the
// fully pipelined cells.
// reset clears the matrix to zero and empties the pipeline and result slot.
// when the receiver stalls, the result stays in the output register and the
// row keeps moving until a finished box reaches its end; then req_tready
// drops until the result is taken.
module frustum_aabb_cull (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // elem_col, elem_row, elem_value, box_min_x, box_min_y, box_min_z,
   // box_max_x, box_max_y, box_max_z, zero fill
   input  logic [fac_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // visible, zero fill
   output logic [fac_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import fac_pkg::*;

   item_type chain [NUM_PLANES+1];
   logic     advance;
   logic     last_box;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   logic     visible_ff;
   logic     visible_in;

   assign last_box   = chain[NUM_PLANES].valid && chain[NUM_PLANES].opcode == OP_BOX;
   assign advance    = !rsp_valid_ff || rsp_tready || !last_box;
   assign req_tready = advance;

   always_comb begin
      chain[0].valid      = req_tvalid && advance;
      chain[0].opcode     = opcode_type'(req_tuser[0]);
      chain[0].elem_col   = req_tdata[1:0];
      chain[0].elem_row   = req_tdata[3:2];
      chain[0].elem_value = req_tdata[35:4];
      chain[0].box_min_x  = req_tdata[67:36];
      chain[0].box_min_y  = req_tdata[99:68];
      chain[0].box_min_z  = req_tdata[131:100];
      chain[0].box_max_x  = req_tdata[163:132];
      chain[0].box_max_y  = req_tdata[195:164];
      chain[0].box_max_z  = req_tdata[227:196];
      chain[0].visible    = 1'b1;
   end

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      fac_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift_en    (advance),
         .plane_row   (2'(p / 2)),
         .plane_minus (1'(p % 2)),
         .item_in     (chain[p]),
         .item_out    (chain[p+1])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      visible_in   = visible_ff;
      if (advance && last_box) begin
         rsp_valid_in = 1'b1;
         visible_in   = chain[NUM_PLANES].visible;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      visible_ff <= visible_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W-1)'(0), visible_ff};

   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input blocked with empty result slot");

   a_block_on_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && last_box) |-> !req_tready)
      else $error("pipeline advanced over a stalled result");

   a_box_delivered : assert property (@(posedge clock) disable iff (reset)
      (advance && last_box) |=> rsp_valid_ff)
      else $error("finished box not placed in result slot");

endmodule

[hw/rtl/fac_cell.sv]
module fac_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  logic [1:0]        plane_row,
   input  logic              plane_minus,
   input  fac_pkg::item_type item_in,
   output fac_pkg::item_type item_out
);
   import fac_pkg::*;

   elem_type r3_ff [4];
   elem_type r3_in [4];
   elem_type rk_ff [4];
   elem_type rk_in [4];
   coef_type coef_ff [4];
   coef_type coef_in [4];

   item_type a_item_ff;
   prod_type a_prod_ff [3];
   prod_type a_prod_in [3];
   coef_type a_d_ff;

   item_type b_item_ff;
   sum_type  b_s01_ff;
   sum_type  b_s2d_ff;
   sum_type  b_s01_in;
   sum_type  b_s2d_in;

   item_type c_item_ff;
   item_type c_item_in;
   sum_type  total;

   elem_type corner_min [3];
   elem_type corner_max [3];

   // matrix rows held by this plane, updated as write transactions pass
   always_comb begin
      r3_in = r3_ff;
      rk_in = rk_ff;
      if (shift_en && item_in.valid && item_in.opcode == OP_WRITE) begin
         if (item_in.elem_row == 2'd3) begin
            r3_in[item_in.elem_col] = item_in.elem_value;
         end
         if (item_in.elem_row == plane_row) begin
            rk_in[item_in.elem_col] = item_in.elem_value;
         end
      end
      for (int i = 0; i < 4; i++) begin
         if (plane_minus) begin
            coef_in[i] = COEF_W'(r3_in[i]) - COEF_W'(rk_in[i]);
         end else begin
            coef_in[i] = COEF_W'(r3_in[i]) + COEF_W'(rk_in[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            r3_ff[i]   <= '0;
            rk_ff[i]   <= '0;
            coef_ff[i] <= '0;
         end
      end else if (shift_en) begin
         r3_ff   <= r3_in;
         rk_ff   <= rk_in;
         coef_ff <= coef_in;
      end
   end

   // stage a: corner select and products
   always_comb begin
      corner_min[0] = item_in.box_min_x;
      corner_min[1] = item_in.box_min_y;
      corner_min[2] = item_in.box_min_z;
      corner_max[0] = item_in.box_max_x;
      corner_max[1] = item_in.box_max_y;
      corner_max[2] = item_in.box_max_z;
      for (int i = 0; i < 3; i++) begin
         if (coef_ff[i][COEF_W-1]) begin
            a_prod_in[i] = PROD_W'(coef_ff[i]) * PROD_W'(corner_min[i]);
         end else begin
            a_prod_in[i] = PROD_W'(coef_ff[i]) * PROD_W'(corner_max[i]);
         end
      end
   end

   // stage b: partial sums, offset aligned to product scale
   always_comb begin
      b_s01_in = SUM_W'(a_prod_ff[0]) + SUM_W'(a_prod_ff[1]);
      b_s2d_in = SUM_W'(a_prod_ff[2]) + (SUM_W'(a_d_ff) <<< FRAC_BITS);
   end

   // stage c: final sum and plane verdict
   always_comb begin
      total     = b_s01_ff + b_s2d_ff;
      c_item_in = b_item_ff;
      if (b_item_ff.opcode == OP_BOX && total[SUM_W-1]) begin
         c_item_in.visible = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_item_ff.valid <= 1'b0;
         b_item_ff.valid <= 1'b0;
         c_item_ff.valid <= 1'b0;
      end else if (shift_en) begin
         a_item_ff <= item_in;
         b_item_ff <= a_item_ff;
         c_item_ff <= c_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         a_prod_ff <= a_prod_in;
         a_d_ff    <= coef_ff[3];
         b_s01_ff  <= b_s01_in;
         b_s2d_ff  <= b_s2d_in;
      end
   end

   assign item_out = c_item_ff;

endmodule
